// File: rtl/ccs_pkg.sv
// Package for the C comment stripper.
// Holds the character codes, item kinds and the result types shared by all but the interfaces.
// Depends on nothing.
package ccs_pkg;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] out_char;
        logic       line_end;
        logic       last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// File: rtl/ccs_in_if.sv
// Input channel of the C comment stripper: one source character or line end per beat.
// Depends on nothing.
interface ccs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink (input valid, input kind, input char_code, output ready);
endinterface

// File: rtl/ccs_out_if.sv
// Output channel of the C comment stripper: one kept character or line end per beat.
// Depends on nothing.
interface ccs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       line_end;
    logic       last_of_run;

    modport source (output valid, output out_char, output line_end, output last_of_run,
                    input ready);
    modport sink (input valid, input out_char, input line_end, input last_of_run,
                  output ready);
endinterface

// File: rtl/ccs_core.sv
// Comment recognizer of the C comment stripper: state flags and the results of one beat.
// Depends on ccs_pkg.
module ccs_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic            i_kind,
    input  logic [7:0]      i_char_code,
    output ccs_pkg::t_push  o_push
);

    logic r_in_block;
    logic r_in_string;
    logic r_pend_slash;
    logic r_pend_star;
    logic r_cutting;

    logic n_in_block;
    logic n_in_string;
    logic n_pend_slash;
    logic n_pend_star;
    logic n_cutting;

    logic [1:0]       cnt;
    logic [7:0]       ch0;
    logic [7:0]       ch1;
    logic             eol0;
    logic             eol1;
    logic             quote_hit;
    logic             str_flip;
    logic             plain_hold;

    assign quote_hit  = (i_char_code == ccs_pkg::CH_QUOTE);
    assign str_flip   = r_in_string ^ quote_hit;
    assign plain_hold = !str_flip && (i_char_code == ccs_pkg::CH_SLASH);

    always_comb begin
        n_in_block   = r_in_block;
        n_in_string  = r_in_string;
        n_pend_slash = r_pend_slash;
        n_pend_star  = r_pend_star;
        n_cutting    = r_cutting;
        cnt          = 2'd0;
        ch0          = i_char_code;
        ch1          = i_char_code;
        eol0         = 1'b0;
        eol1         = 1'b0;
        priority if (i_kind == ccs_pkg::KIND_EOL) begin
            if (r_pend_slash) begin
                cnt  = 2'd2;
                ch0  = ccs_pkg::CH_SLASH;
                ch1  = 8'd0;
                eol1 = 1'b1;
            end else begin
                cnt  = 2'd1;
                ch0  = 8'd0;
                eol0 = 1'b1;
            end
            n_in_string  = 1'b0;
            n_pend_slash = 1'b0;
            n_pend_star  = 1'b0;
            n_cutting    = 1'b0;
        end else if (r_cutting) begin
            cnt = 2'd0;
        end else if (r_in_block) begin
            if (r_pend_star && i_char_code == ccs_pkg::CH_SLASH) begin
                n_in_block  = 1'b0;
                n_pend_star = 1'b0;
            end else begin
                n_pend_star = (i_char_code == ccs_pkg::CH_STAR);
            end
        end else if (r_pend_slash) begin
            n_pend_slash = 1'b0;
            if (i_char_code == ccs_pkg::CH_SLASH) begin
                n_cutting = 1'b1;
            end else if (i_char_code == ccs_pkg::CH_STAR) begin
                n_in_block  = 1'b1;
                n_pend_star = 1'b0;
            end else begin
                n_in_string  = str_flip;
                n_pend_slash = plain_hold;
                ch0          = ccs_pkg::CH_SLASH;
                cnt          = plain_hold ? 2'd1 : 2'd2;
            end
        end else begin
            n_in_string  = str_flip;
            n_pend_slash = plain_hold;
            cnt          = plain_hold ? 2'd0 : 2'd1;
        end
    end

    always_comb begin
        o_push.count              = cnt;
        o_push.first.out_char     = ch0;
        o_push.first.line_end     = eol0;
        o_push.first.last_of_run  = (cnt == 2'd1);
        o_push.second.out_char    = ch1;
        o_push.second.line_end    = eol1;
        o_push.second.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_block   <= 1'b0;
            r_in_string  <= 1'b0;
            r_pend_slash <= 1'b0;
            r_pend_star  <= 1'b0;
            r_cutting    <= 1'b0;
        end else if (i_fire) begin
            r_in_block   <= n_in_block;
            r_in_string  <= n_in_string;
            r_pend_slash <= n_pend_slash;
            r_pend_star  <= n_pend_star;
            r_cutting    <= n_cutting;
        end
    end

endmodule

// File: rtl/ccs_out_queue.sv
// Result queue of the C comment stripper: takes up to two results a cycle, sends one beat when ready.
// Depends on ccs_pkg.
module ccs_out_queue #(
    parameter int DEPTH = ccs_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_en,
    input  ccs_pkg::t_push    i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output ccs_pkg::t_result  o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ccs_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    logic [AW-1:0]    wr_ptr_1;
    logic [1:0]       push_n;
    logic             pop;

    assign push_n   = i_push_en ? i_push.count : 2'd0;
    assign pop      = o_valid && i_ready;
    assign wr_ptr_1 = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
    assign o_valid  = (r_count != '0);
    assign o_room   = (r_count <= CW'(DEPTH - 2));
    assign o_result = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (push_n == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_n == 2'd1) begin
                r_wr_ptr <= wr_ptr_1;
            end else if (push_n == 2'd2) begin
                r_wr_ptr <= (wr_ptr_1 == AW'(DEPTH - 1)) ? '0 : wr_ptr_1 + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            r_count <= r_count + CW'(push_n) - CW'(pop);
        end
    end

endmodule

// File: rtl/c_comment_stripper.sv
// C comment stripper, top level. Depends on ccs_pkg, ccs_in_if, ccs_out_if, ccs_core
// and ccs_out_queue.
// Order: results of an accepted input beat are queued and offered in arrival order.
// Throughput: one input and one output beat per cycle, output while the sink is ready;
// the queue decides acceptance and takes a beat while it has room for two more results.
// Reset: synchronous; clears the comment and string flags and empties the queue.
module c_comment_stripper #(
    parameter int QUEUE_DEPTH = ccs_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccs_in_if.sink      i_src,
    ccs_out_if.source   o_res
);

    ccs_pkg::t_push   push;
    ccs_pkg::t_result head;
    logic             room;
    logic             fire;

    assign i_src.ready = room;
    assign fire        = i_src.valid && room;

    ccs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_kind      (i_src.kind),
        .i_char_code (i_src.char_code),
        .o_push      (push)
    );

    ccs_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (fire),
        .i_push    (push),
        .o_room    (room),
        .o_valid   (o_res.valid),
        .i_ready   (o_res.ready),
        .o_result  (head)
    );

    assign o_res.out_char    = head.out_char;
    assign o_res.line_end    = head.line_end;
    assign o_res.last_of_run = head.last_of_run;

endmodule

// File: tb/ccs_strip_check.sv
// Result checker for the C comment stripper: watches both channels, predicts the cleaned
// text of every accepted input beat and compares it with each accepted output beat.
// Depends on ccs_pkg, ccs_in_if and ccs_out_if.
module ccs_strip_check (
    input  logic i_clk,
    input  logic i_rst_n,
    ccs_in_if    i_src,
    ccs_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    ccs_pkg::t_result kept_q[$];
    logic    in_block;
    logic    in_string;
    logic    held_slash;
    logic    held_star;
    logic    cutting;
    int      fails;

    assign o_fail_count = fails;

    initial begin
        fails      = 0;
        in_block   = 1'b0;
        in_string  = 1'b0;
        held_slash = 1'b0;
        held_star  = 1'b0;
        cutting    = 1'b0;
    end

    task automatic report_mismatch(input string what, input ccs_pkg::t_result got,
                                   input ccs_pkg::t_result exp);
        $display("%0t mismatch (%s): got %02h/%b/%b, expected %02h/%b/%b",
                 $realtime, what, got.out_char, got.line_end, got.last_of_run,
                 exp.out_char, exp.line_end, exp.last_of_run);
        fails++;
    endtask

    task automatic push_kept(input logic [7:0] ch, input logic eol);
        ccs_pkg::t_result r;
        r.out_char    = ch;
        r.line_end    = eol;
        r.last_of_run = 1'b0;
        kept_q = {kept_q, r};
    endtask

    task automatic plain_char(input logic [7:0] c);
        if (c == ccs_pkg::CH_QUOTE) begin
            in_string = !in_string;
        end
        if (!in_string && c == ccs_pkg::CH_SLASH) begin
            held_slash = 1'b1;
        end else begin
            push_kept(c, 1'b0);
        end
    endtask

    task automatic strip_beat(input logic kind, input logic [7:0] c);
        int start;
        start = kept_q.size();
        if (kind == ccs_pkg::KIND_EOL) begin
            if (held_slash) begin
                push_kept(ccs_pkg::CH_SLASH, 1'b0);
            end
            push_kept(8'h00, 1'b1);
            in_string  = 1'b0;
            held_slash = 1'b0;
            held_star  = 1'b0;
            cutting    = 1'b0;
        end else if (cutting) begin
            start = kept_q.size();
        end else if (in_block) begin
            if (held_star && c == ccs_pkg::CH_SLASH) begin
                in_block  = 1'b0;
                held_star = 1'b0;
            end else begin
                held_star = (c == ccs_pkg::CH_STAR);
            end
        end else if (held_slash) begin
            held_slash = 1'b0;
            if (c == ccs_pkg::CH_SLASH) begin
                cutting = 1'b1;
            end else if (c == ccs_pkg::CH_STAR) begin
                in_block  = 1'b1;
                held_star = 1'b0;
            end else begin
                push_kept(ccs_pkg::CH_SLASH, 1'b0);
                plain_char(c);
            end
        end else begin
            plain_char(c);
        end
        if (kept_q.size() > start) begin
            kept_q[kept_q.size() - 1].last_of_run = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        ccs_pkg::t_result got;
        ccs_pkg::t_result exp;
        if (i_rst_n) begin
            if (i_res.valid && i_res.ready) begin
                got.out_char    = i_res.out_char;
                got.line_end    = i_res.line_end;
                got.last_of_run = i_res.last_of_run;
                if (kept_q.size() == 0) begin
                    exp = '0;
                    report_mismatch("unexpected beat", got, exp);
                end else begin
                    exp = kept_q.pop_front();
                    if (got.out_char !== exp.out_char || got.line_end !== exp.line_end ||
                        got.last_of_run !== exp.last_of_run) begin
                        report_mismatch("field", got, exp);
                    end
                end
            end
            if (i_src.valid && i_src.ready) begin
                strip_beat(i_src.kind, i_src.char_code);
            end
        end
        o_pending <= kept_q.size();
    end

endmodule

// File: tb/testbench.sv
// Top of the C comment stripper testbench: clock, reset, input beats and output stalls.
// Depends on ccs_pkg, ccs_in_if, ccs_out_if, c_comment_stripper and ccs_strip_check.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_BEATS = 1000;
    localparam int QUIET_TAIL   = 150;
    localparam int TAIL_CYCLES  = 10;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   beats_sent;
    int   gap_pct;
    int   cycle_count;
    logic quiet;

    ccs_in_if  src_if ();
    ccs_out_if res_if ();

    c_comment_stripper i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_if),
        .o_res   (res_if)
    );

    ccs_strip_check i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_src        (src_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[c_comment_stripper] ERROR");
        $finish;
    end

    initial begin
        res_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    task automatic send_beat(input logic kind, input logic [7:0] code);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            src_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        src_if.valid     <= 1'b1;
        src_if.kind      <= kind;
        src_if.char_code <= code;
        do @(posedge i_clk); while (!src_if.ready);
        beats_sent++;
    endtask

    task automatic send_line(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_beat(ccs_pkg::KIND_CHAR, text[i]);
        end
        send_beat(ccs_pkg::KIND_EOL, 8'($urandom));
    endtask

    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            return ccs_pkg::CH_SLASH;
        end else if (pick < 27) begin
            return ccs_pkg::CH_STAR;
        end else if (pick < 35) begin
            return ccs_pkg::CH_QUOTE;
        end else if (pick < 45) begin
            return 8'($urandom);
        end else if (pick < 50) begin
            return 8'h20;
        end
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    initial begin
        int len;
        logic noise;
        quiet            = 1'b0;
        gap_pct          = 30;
        beats_sent       = 0;
        i_rst_n          <= 1'b0;
        src_if.valid     <= 1'b0;
        src_if.kind      <= ccs_pkg::KIND_CHAR;
        src_if.char_code <= 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_line("");
        send_beat(ccs_pkg::KIND_CHAR, 8'h00);
        send_beat(ccs_pkg::KIND_CHAR, ccs_pkg::CH_SLASH);
        send_beat(ccs_pkg::KIND_CHAR, 8'hFF);
        send_beat(ccs_pkg::KIND_EOL, 8'hFF);
        send_line("x/");
        send_line("//z");
        send_line("\"/*\"");
        send_line("/*/*");
        send_line("/x*/");

        while (beats_sent < RANDOM_BEATS) begin
            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
            quiet   = (beats_sent > RANDOM_BEATS - QUIET_TAIL);
            len     = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                                  : $urandom_range(0, 10);
            noise   = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
                send_beat(ccs_pkg::KIND_CHAR, noise ? 8'($urandom) : random_char());
            end
            send_beat(ccs_pkg::KIND_EOL, 8'($urandom));
        end
        src_if.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[c_comment_stripper] OK");
        end else begin
            $display("[c_comment_stripper] ERROR");
        end
        $finish;
    end

endmodule
